// File: hw/rtl/tpsd_pkg.sv
// Shared types and constants for the tape pulse stream decoder.
// It depends on nothing else. The front end, the scaler and the top level import it.
`default_nettype none

package tpsd_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 32;
    localparam int OPERAND_W = 24;
    localparam int HALF_W    = 26;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int FMT_W     = 2;
    localparam int PLAT_W    = 2;

    localparam int SCALE_FRAC_BITS_DEF = 16;

    // These are the configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATFORM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd3;

    // These are the format codes.
    localparam logic [FMT_W-1:0] FMT_PLAIN = 2'd0;
    localparam logic [FMT_W-1:0] FMT_LONG  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_HALF  = 2'd2;

    // These are the platform codes. Any other code selects the first clock set.
    localparam logic [PLAT_W-1:0] PLAT_ONE = 2'd1;
    localparam logic [PLAT_W-1:0] PLAT_TWO = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RESET = FMT_LONG;

    // These are the machine clock rates in Hz, one pair of PAL and NTSC per platform.
    localparam longint CLK_P0_PAL  = 985248;
    localparam longint CLK_P0_NTSC = 1022272;
    localparam longint CLK_P1_PAL  = 1108404;
    localparam longint CLK_P1_NTSC = 1022727;
    localparam longint CLK_P2_PAL  = 886724;
    localparam longint CLK_P2_NTSC = 894886;
    localparam longint US_PER_SECOND = 1000000;

    // This is one scaling request handed from the front end to the scaler.
    typedef struct packed {
        logic                 is_end;
        logic                 fmt2;
        logic                 level;
        logic [OPERAND_W-1:0] operand;
    } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpsd_front.sv
// Front end of the tape pulse stream decoder. It holds the configuration registers and
// the stream state, and it turns each accepted byte into at most one scaling request.
// It depends on tpsd_pkg.
`default_nettype none

module tpsd_front (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    input  wire  [tpsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tpsd_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire                            in_accept,
    input  wire  [tpsd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           op_valid,
    output tpsd_pkg::op_t                  op,
    output logic [tpsd_pkg::PLAT_W-1:0]    platform,
    output logic                           video_standard
);
    import tpsd_pkg::*;

    logic [FMT_W-1:0]     format_reg;
    logic [PLAT_W-1:0]    platform_reg;
    logic                 video_reg;
    logic [POS_W-1:0]     length_reg;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [1:0]           left_reg, left_next;
    logic [OPERAND_W-1:0] acc_reg, acc_next;
    logic                 shn_reg, shn_next;
    logic                 done_reg, done_next;

    logic                 fmt2;
    logic                 pulse;
    logic [BYTE_W:0]      short_val;

    assign fmt2           = (format_reg == FMT_HALF);
    assign platform       = platform_reg;
    assign video_standard = video_reg;
    assign short_val      = (data_byte == '0) ? {1'b1, {BYTE_W{1'b0}}} : {1'b0, data_byte};

    always_comb
    begin
        pos_next  = pos_reg;
        left_next = left_reg;
        acc_next  = acc_reg;
        shn_next  = shn_reg;
        done_next = done_reg;
        op_valid  = 1'b0;
        pulse     = 1'b0;
        op        = '0;
        op.fmt2   = fmt2;
        if (in_accept)
        begin
            if (done_reg)
            begin
                op_valid  = 1'b1;
                op.is_end = 1'b1;
            end
            else if (left_reg == 2'd0 && !(fmt2 && shn_reg) && pos_reg >= length_reg)
            begin
                done_next = 1'b1;
                op_valid  = 1'b1;
                op.is_end = 1'b1;
            end
            else
            begin
                if (pos_reg != '1)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                if (left_reg != 2'd0)
                begin
                    case (left_reg)
                        2'd3:    acc_next = acc_reg | {16'd0, data_byte};
                        2'd2:    acc_next = acc_reg | {8'd0, data_byte, 8'd0};
                        default: acc_next = acc_reg | {data_byte, 16'd0};
                    endcase
                    left_next = left_reg - 2'd1;
                    if (left_reg == 2'd1)
                    begin
                        pulse      = 1'b1;
                        op.operand = acc_next;
                    end
                end
                else if (data_byte == '0 && format_reg != FMT_PLAIN)
                begin
                    left_next = 2'd3;
                    acc_next  = '0;
                end
                else
                begin
                    pulse      = 1'b1;
                    op.operand = OPERAND_W'({short_val, 3'b000});
                end
                if (pulse)
                begin
                    op_valid = 1'b1;
                    op.level = shn_reg;
                    shn_next = fmt2 ? !shn_reg : 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg   <= FMT_RESET;
            platform_reg <= '0;
            video_reg    <= 1'b0;
            length_reg   <= '0;
            pos_reg      <= '0;
            left_reg     <= '0;
            acc_reg      <= '0;
            shn_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            left_reg <= left_next;
            acc_reg  <= acc_next;
            shn_reg  <= shn_next;
            done_reg <= done_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_FORMAT:   format_reg   <= cfg_data[FMT_W-1:0];
                    CFG_PLATFORM: platform_reg <= cfg_data[PLAT_W-1:0];
                    CFG_VIDEO:    video_reg    <= cfg_data[0];
                    CFG_LENGTH:   length_reg   <= cfg_data;
                    default:      length_reg   <= length_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tpsd_scale.sv
// Scaler and result stage of the tape pulse stream decoder. It holds the request register,
// the period multiplier and the result register that splits a value into two halves.
// It depends on tpsd_pkg.
`default_nettype none

module tpsd_scale #(
    parameter int SCALE_FRAC_BITS = tpsd_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            op_valid,
    input  wire  tpsd_pkg::op_t            op,
    output logic                           op_ready,
    input  wire  [tpsd_pkg::PLAT_W-1:0]    platform,
    input  wire                            video_standard,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [tpsd_pkg::HALF_W-1:0]    half_length,
    output logic                           line_level,
    output logic                           end_of_tape,
    output logic                           last_of_run
);
    import tpsd_pkg::*;

    localparam int PW = SCALE_FRAC_BITS + 1;
    localparam int MW = OPERAND_W + PW;
    localparam longint NUM = US_PER_SECOND << SCALE_FRAC_BITS;
    localparam logic [PW-1:0] PER_P0_PAL  = PW'((NUM + CLK_P0_PAL / 2) / CLK_P0_PAL);
    localparam logic [PW-1:0] PER_P0_NTSC = PW'((NUM + CLK_P0_NTSC / 2) / CLK_P0_NTSC);
    localparam logic [PW-1:0] PER_P1_PAL  = PW'((NUM + CLK_P1_PAL / 2) / CLK_P1_PAL);
    localparam logic [PW-1:0] PER_P1_NTSC = PW'((NUM + CLK_P1_NTSC / 2) / CLK_P1_NTSC);
    localparam logic [PW-1:0] PER_P2_PAL  = PW'((NUM + CLK_P2_PAL / 2) / CLK_P2_PAL);
    localparam logic [PW-1:0] PER_P2_NTSC = PW'((NUM + CLK_P2_NTSC / 2) / CLK_P2_NTSC);

    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic              out_valid_reg;
    logic [HALF_W-1:0] len_reg;
    logic              level_reg;
    logic              end_reg;
    logic              last_reg;

    logic [PW-1:0]     period;
    logic [MW-1:0]     product;
    logic [HALF_W-2:0] scaled;
    logic              out_free;
    logic              s1_move;

    always_comb
    begin
        case (platform)
            PLAT_ONE: period = video_standard ? PER_P1_NTSC : PER_P1_PAL;
            PLAT_TWO: period = video_standard ? PER_P2_NTSC : PER_P2_PAL;
            default:  period = video_standard ? PER_P0_NTSC : PER_P0_PAL;
        endcase
    end

    assign product  = MW'(s1_op_reg.operand) * MW'(period);
    assign scaled   = product[SCALE_FRAC_BITS +: HALF_W-1];
    assign out_free = !out_valid_reg || (out_ready && last_reg);
    assign s1_move  = s1_valid_reg && out_free;
    assign op_ready = !s1_valid_reg || s1_move;

    assign out_valid   = out_valid_reg;
    assign half_length = len_reg;
    assign line_level  = level_reg;
    assign end_of_tape = end_reg;
    assign last_of_run = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op_ready)
            begin
                s1_valid_reg <= op_valid;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready && last_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_ready && op_valid)
        begin
            s1_op_reg <= op;
        end
        if (s1_move)
        begin
            if (s1_op_reg.is_end)
            begin
                len_reg   <= '0;
                level_reg <= 1'b0;
                end_reg   <= 1'b1;
                last_reg  <= 1'b1;
            end
            else if (s1_op_reg.fmt2)
            begin
                len_reg   <= {scaled, 1'b0};
                level_reg <= s1_op_reg.level;
                end_reg   <= 1'b0;
                last_reg  <= 1'b1;
            end
            else
            begin
                len_reg   <= {1'b0, scaled};
                level_reg <= 1'b0;
                end_reg   <= 1'b0;
                last_reg  <= 1'b0;
            end
        end
        else if (out_valid_reg && out_ready && !last_reg)
        begin
            level_reg <= 1'b1;
            last_reg  <= 1'b1;
        end
    end

    // A first half is never an end-of-tape result.
    a_first_half_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> !end_reg)
        else $error("first half carries end of tape");

    // A taken first half is followed at once by the high second half.
    a_second_half_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ready && !last_reg
        |=> out_valid_reg && level_reg && last_reg && $stable(len_reg))
        else $error("second half missing or altered");

    // An end-of-tape result carries no pulse.
    a_end_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && end_reg |-> len_reg == '0 && !level_reg && last_reg)
        else $error("end of tape result carries a pulse");

endmodule

`default_nettype wire

// File: hw/rtl/tap_pulse_stream_decoder_unit.sv
// Top level of the tape pulse stream decoder. It ties the front end to the scaler.
// It depends on tpsd_pkg, tpsd_front and tpsd_scale.
//
//  channel   signals                                  direction  carries
//  cfg       cfg_valid/cfg_ready, cfg_index, cfg_data  in         register writes
//  in        in_valid/in_ready, data_byte              in         one raw tape data byte
//  out       out_valid/out_ready, half_length,         out        one half-wave duration
//            line_level, end_of_tape, last_of_run
//
// A byte that is accepted updates the stream state in the same cycle. A byte that
// yields a pulse or an end mark loads the request register, then the period multiplier
// fills the result register once that register is free. A byte gives one result in
// format 2 and at the end of the tape, two results in formats 0 and 1, one result per
// cycle while out_ready is high. The result register sets this rate. Bytes that only
// collect a long count give no result. Reset is asynchronous and active low. It restores
// format 1, platform 0, PAL, length zero and an empty stream. While out_ready is low the
// request register holds one more request. The block takes bytes again as soon as the
// result register frees it. Writes to the configuration registers are always accepted.
`default_nettype none

module tap_pulse_stream_decoder_unit #(
    parameter int SCALE_FRAC_BITS = tpsd_pkg::SCALE_FRAC_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [tpsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [tpsd_pkg::CFG_DAT_W-1:0] cfg_data,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [tpsd_pkg::BYTE_W-1:0]    data_byte,
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [tpsd_pkg::HALF_W-1:0]    half_length,
    output logic                           line_level,
    output logic                           end_of_tape,
    output logic                           last_of_run
);
    import tpsd_pkg::*;

    logic              op_valid;
    op_t               op;
    logic              op_ready;
    logic [PLAT_W-1:0] platform;
    logic              video_standard;
    logic              in_accept;

    // The front end has no backpressure of its own. A byte is taken whenever the
    // request register can take what the byte produces.
    assign cfg_ready = 1'b1;
    assign in_ready  = op_ready;
    assign in_accept = in_valid && op_ready;

    tpsd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_accept      (in_accept),
        .data_byte      (data_byte),
        .op_valid       (op_valid),
        .op             (op),
        .platform       (platform),
        .video_standard (video_standard)
    );

    tpsd_scale #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_scale (
        .clk            (clk),
        .rst_n          (rst_n),
        .op_valid       (op_valid),
        .op             (op),
        .op_ready       (op_ready),
        .platform       (platform),
        .video_standard (video_standard),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .half_length    (half_length),
        .line_level     (line_level),
        .end_of_tape    (end_of_tape),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire
